// File: rtl/touch_hold_repeat_tracker_defines.svh
// Assertion macros shared by the touch hold repeat tracker RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef TOUCH_HOLD_REPEAT_TRACKER_DEFINES_SVH
`define TOUCH_HOLD_REPEAT_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define THR_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define THR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/thr_pkg.sv
// Package for the touch hold repeat tracker: widths, register map, types.
// No dependencies; imported by every other RTL file except the defines header.
package thr_pkg;

	localparam int SENSORS   = 3;
	localparam int PIN_W     = 3;
	localparam int SIDX_W    = 2;
	localparam int DUR_W     = 32;
	localparam int IVL_W     = 16;
	localparam int BEEP_W    = 8;
	localparam int STEP_W    = $clog2(DUR_W);
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_BEEP_INTERVAL = '0;
	localparam logic [IVL_W-1:0]     BEEP_INTERVAL_RST = IVL_W'(1000);
	localparam logic [BEEP_W-1:0]    BEEP_MAX          = '1;
	localparam logic [SIDX_W-1:0]    LAST_SENSOR       = SIDX_W'(SENSORS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_BEEP,
		ST_EMIT
	} thr_state_t;

	typedef struct packed {
		logic             start;
		logic [DUR_W-1:0] dividend;
		logic [IVL_W-1:0] divisor;
	} thr_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DUR_W-1:0] quotient;
	} thr_div_rsp_t;

endpackage

// File: rtl/thr_update_if.sv
// Update channel: time stamp and touch levels, valid/ready handshake.
// Depends on thr_pkg.
interface thr_update_if
	import thr_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [DUR_W-1:0] now_ms;
	logic [PIN_W-1:0] pin_levels;

	modport source (output valid, now_ms, pin_levels, input ready);
	modport sink   (input valid, now_ms, pin_levels, output ready);
endinterface

// File: rtl/thr_result_if.sv
// Result channel: one item per channel per update, valid/ready handshake.
// Depends on thr_pkg.
interface thr_result_if
	import thr_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [SIDX_W-1:0] sensor_index;
	logic              just_pressed;
	logic              just_released;
	logic              held;
	logic [DUR_W-1:0]  hold_duration_ms;
	logic [BEEP_W-1:0] beep_count;
	logic              beep_event;
	logic              last;

	modport source (output valid, sensor_index, just_pressed, just_released, held,
		hold_duration_ms, beep_count, beep_event, last, input ready);
	modport sink   (input valid, sensor_index, just_pressed, just_released, held,
		hold_duration_ms, beep_count, beep_event, last, output ready);
endinterface

// File: rtl/thr_div.sv
// Bit-serial restoring divider: one quotient bit per cycle over the DUR_W dividend bits.
// Depends on thr_pkg.
module thr_div
	import thr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  thr_div_req_t req,
	output thr_div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DUR_W-1:0]  quo_q;
	logic [IVL_W-1:0]  rem_q;
	logic [IVL_W-1:0]  dvs_q;

	logic [IVL_W:0]    shifted;
	logic              fits;
	logic [IVL_W:0]    diff;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		shifted = {rem_q, quo_q[DUR_W-1]};
		fits    = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(DUR_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DUR_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DUR_W-2:0], fits};
			rem_q <= fits ? diff[IVL_W-1:0] : shifted[IVL_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: rtl/touch_hold_repeat_tracker.sv
// Touch hold repeat tracker top level: channel sequencer, state, output register.
// Depends on thr_pkg, thr_update_if, thr_result_if, thr_div and the defines header.
// Usage:
//   upd  - one item per time step: now_ms and one touch level per channel.
//   res  - SENSORS items per update, channel 0 first, the final one has last set.
//   APB  - register 0 (byte address 0) is beep_interval_ms, reset 1000; zero
//          switches beep events off. Write only while the block is idle.
// Sequencing:
//   Each channel passes ST_EVAL and ST_EMIT, with ST_DIV and ST_BEEP between
//   them when it is touched and the interval is non-zero: the hold time is
//   divided by the interval in a bit-serial divider that retires one quotient
//   bit per cycle over 32 bits. The next update is taken once the last result
//   has moved into the output register, even while that result still waits.
// Reset:
//   All channels read untouched with zero press time and zero beeps, the
//   interval returns to 1000 and no result is pending.
// Stall:
//   A result holds in the output register until taken; the sequencer waits
//   in front of it and loses nothing.
`include "touch_hold_repeat_tracker_defines.svh"

module touch_hold_repeat_tracker
	import thr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	thr_update_if.sink          upd,
	thr_result_if.source        res,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	// Configuration register
	logic [IVL_W-1:0]  interval_q;

	// Sequencer
	thr_state_t        state_q, state_d;
	logic [SIDX_W-1:0] ch_q;

	// Captured update
	logic [DUR_W-1:0]  now_q;
	logic [PIN_W-1:0]  pin_q;

	// Per-channel state
	logic              prev_q  [SENSORS];
	logic [DUR_W-1:0]  start_q [SENSORS];
	logic [BEEP_W-1:0] beeps_q [SENSORS];

	// Working values of the channel in hand
	logic              cur_q, was_q, ev_q;
	logic [DUR_W-1:0]  dur_q;
	logic [BEEP_W-1:0] bcnt_q;

	// Output register
	logic              rvalid_q;
	logic [SIDX_W-1:0] ridx_q;
	logic              rpress_q, rrel_q, rheld_q, rev_q, rlast_q;
	logic [DUR_W-1:0]  rdur_q;
	logic [BEEP_W-1:0] rcnt_q;

	// Combinational
	logic              cur_w, was_w;
	logic [DUR_W-1:0]  start_w, dur_w;
	logic [BEEP_W-1:0] base_w, expect_w;
	logic              take_upd, emit_fire, div_go, cfg_wr;
	thr_div_req_t      div_req;
	thr_div_rsp_t      div_rsp;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_BEEP_INTERVAL);

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1:2] == REG_BEEP_INTERVAL) begin
			prdata = PDATA_W'(interval_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= BEEP_INTERVAL_RST;
		end else if (cfg_wr) begin
			interval_q <= pwdata[IVL_W-1:0];
		end
	end

	// ---------------- channel evaluation ----------------
	// Channels above the pin field read untouched. A press restarts the hold
	// clock and the beep count; a release clears both.
	always_comb begin
		cur_w = 1'b0;
		if (ch_q < SIDX_W'(PIN_W)) begin
			cur_w = pin_q[ch_q];
		end
		was_w   = prev_q[ch_q];
		start_w = cur_w ? (was_w ? start_q[ch_q] : now_q) : '0;
		dur_w   = cur_w ? (now_q - start_w) : '0;
		base_w  = (cur_w && was_w) ? beeps_q[ch_q] : '0;
		// Clamp the quotient to the counter range.
		expect_w = (|div_rsp.quotient[DUR_W-1:BEEP_W]) ? BEEP_MAX
			: div_rsp.quotient[BEEP_W-1:0];
	end

	assign div_req.start    = div_go;
	assign div_req.dividend = dur_w;
	assign div_req.divisor  = interval_q;

	thr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		take_upd  = 1'b0;
		emit_fire = 1'b0;
		div_go    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				take_upd = upd.valid;
				if (upd.valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (cur_w && (interval_q != '0)) begin
					div_go  = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_BEEP;
				end
			end
			ST_BEEP: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// Load the output register once it is empty or being drained.
				if (!rvalid_q || res.ready) begin
					emit_fire = 1'b1;
					state_d   = (ch_q == LAST_SENSOR) ? ST_IDLE : ST_EVAL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign upd.ready = (state_q == ST_IDLE);

	// Channel counter and per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			for (int i = 0; i < SENSORS; i++) begin
				prev_q[i]  <= 1'b0;
				start_q[i] <= '0;
				beeps_q[i] <= '0;
			end
		end else begin
			if (take_upd) begin
				ch_q <= '0;
			end else if (emit_fire && (ch_q != LAST_SENSOR)) begin
				ch_q <= ch_q + 1'b1;
			end
			if (state_q == ST_EVAL) begin
				prev_q[ch_q]  <= cur_w;
				start_q[ch_q] <= start_w;
				beeps_q[ch_q] <= base_w;
			end else if ((state_q == ST_BEEP) && (expect_w > bcnt_q)) begin
				beeps_q[ch_q] <= expect_w;
			end
		end
	end

	// Update capture and working values
	always_ff @(posedge clk) begin
		if (take_upd) begin
			now_q <= upd.now_ms;
			pin_q <= upd.pin_levels;
		end
		if (state_q == ST_EVAL) begin
			cur_q  <= cur_w;
			was_q  <= was_w;
			dur_q  <= dur_w;
			bcnt_q <= base_w;
			ev_q   <= 1'b0;
		end else if ((state_q == ST_BEEP) && (expect_w > bcnt_q)) begin
			bcnt_q <= expect_w;
			ev_q   <= 1'b1;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (emit_fire) begin
			rvalid_q <= 1'b1;
		end else if (res.ready) begin
			rvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			ridx_q   <= ch_q;
			rpress_q <= cur_q && !was_q;
			rrel_q   <= !cur_q && was_q;
			rheld_q  <= cur_q;
			rdur_q   <= dur_q;
			rcnt_q   <= bcnt_q;
			rev_q    <= ev_q;
			rlast_q  <= (ch_q == LAST_SENSOR);
		end
	end

	assign res.valid            = rvalid_q;
	assign res.sensor_index     = ridx_q;
	assign res.just_pressed     = rpress_q;
	assign res.just_released    = rrel_q;
	assign res.held             = rheld_q;
	assign res.hold_duration_ms = rdur_q;
	assign res.beep_count       = rcnt_q;
	assign res.beep_event       = rev_q;
	assign res.last             = rlast_q;

	// ---------------- assertions ----------------
	`THR_ASSERT_IMPLY(a_div_done_in_div, div_rsp.done, state_q == ST_DIV, "divider done outside divide state")
	`THR_ASSERT_NEXT(a_last_to_idle, emit_fire && (ch_q == LAST_SENSOR), state_q == ST_IDLE && rlast_q, "last channel did not close the update")
	`THR_ASSERT_IMPLY(a_event_needs_hold, res.valid && res.beep_event, res.held && (res.beep_count != '0), "beep event without hold")
	`THR_ASSERT_IMPLY(a_press_zero_dur, res.valid && res.just_pressed, (res.hold_duration_ms == '0) && (res.beep_count == '0), "press item carries time or beeps")

endmodule

// File: dv/tb_touch_hold_repeat_tracker.sv
// Self-checking testbench for touch_hold_repeat_tracker: directed and random updates,
// scoreboarded results and APB writes of the beep interval.
// Depends on thr_pkg, thr_update_if, thr_result_if and the tracker RTL.
`timescale 1ns / 100ps

module tb_touch_hold_repeat_tracker;
	import thr_pkg::*;

	// Idle time at the end, long enough for a whole update to settle.
	localparam int unsigned SETTLE_CYCLES = 150;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	typedef enum {PACE_NONE, PACE_SRC, PACE_SNK, PACE_BOTH} pace_t;

	typedef struct {
		logic [DUR_W-1:0] now_ms;
		logic [PIN_W-1:0] pin_levels;
	} update_t;

	typedef struct {
		logic [SIDX_W-1:0] sensor_index;
		logic              just_pressed;
		logic              just_released;
		logic              held;
		logic [DUR_W-1:0]  hold_duration_ms;
		logic [BEEP_W-1:0] beep_count;
		logic              beep_event;
		logic              last;
	} result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	thr_update_if upd_if ();
	thr_result_if res_if ();

	touch_hold_repeat_tracker i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Updates waiting for the driver, and per-channel results still owed by the block.
	update_t pending_updates[$];
	result_t owed_results[$];

	// Own copy of the tracker state, advanced on every accepted update.
	logic              was_touched [SENSORS];
	logic [DUR_W-1:0]  press_ms    [SENSORS];
	logic [BEEP_W-1:0] beeps_held  [SENSORS];
	logic [IVL_W-1:0]  beep_ivl;

	pace_t        pace;
	bit           drain_hold;
	logic [DUR_W-1:0] stim_now;
	logic [PIN_W-1:0] stim_lv;

	int unsigned mismatches;
	int unsigned updates_taken;
	int unsigned results_checked;
	int unsigned beep_events_seen;
	int unsigned settings_written;
	int unsigned cycle_count;

	// Clock: 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Decide whether one side idles this cycle, according to the current pace.
	function automatic bit idle_roll(input bit sender);
		int unsigned pct;
		pct = 0;
		case (pace)
			PACE_SRC:  pct = sender ? 49 : 0;
			PACE_SNK:  pct = sender ? 0 : 49;
			PACE_BOTH: pct = 17;
			default:   pct = 0;
		endcase
		return $urandom_range(0, 99) < pct;
	endfunction

	// Advance the channel state by one update and queue the results it owes.
	function automatic void track_update(input logic [DUR_W-1:0] now,
		input logic [PIN_W-1:0] levels);
		result_t          r;
		logic             cur;
		logic             was;
		logic             rose;
		logic [DUR_W-1:0] dur;
		logic [DUR_W-1:0] quo;
		for (int ch = 0; ch < SENSORS; ch++) begin
			// channels beyond the level field would read untouched
			cur  = (ch < PIN_W) ? levels[ch] : 1'b0;
			was  = was_touched[ch];
			dur  = '0;
			rose = 1'b0;
			if (cur) begin
				// a fresh press restarts the clock before measuring
				if (!was) begin
					press_ms[ch]   = now;
					beeps_held[ch] = '0;
				end
				dur = now - press_ms[ch];
				if (beep_ivl != '0) begin
					quo = dur / beep_ivl;
					if (quo > BEEP_MAX)
						quo = BEEP_MAX;
					if (quo > beeps_held[ch]) begin
						beeps_held[ch] = quo[BEEP_W-1:0];
						rose = 1'b1;
					end
				end
			end else begin
				beeps_held[ch] = '0;
				press_ms[ch]   = '0;
			end
			was_touched[ch] = cur;

			r.sensor_index     = SIDX_W'(ch);
			r.just_pressed     = cur && !was;
			r.just_released    = !cur && was;
			r.held             = cur;
			r.hold_duration_ms = dur;
			r.beep_count       = cur ? beeps_held[ch] : '0;
			r.beep_event       = rose;
			r.last             = (ch == SENSORS - 1);
			owed_results.push_back(r);
		end
	endfunction

	function automatic void check_field(input string name, input logic [DUR_W-1:0] want,
		input logic [DUR_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Driver: hold an offered item until taken, then offer the next one or idle.
	always @(posedge clk) begin
		update_t nxt;
		if (!arst_n) begin
			upd_if.valid <= 1'b0;
		end else begin
			if (upd_if.valid && upd_if.ready) begin
				track_update(upd_if.now_ms, upd_if.pin_levels);
				updates_taken++;
			end
			if (!upd_if.valid || upd_if.ready) begin
				if (pending_updates.size() != 0 && !idle_roll(1'b1) &&
					!(drain_hold && owed_results.size() != 0)) begin
					nxt = pending_updates.pop_front();
					upd_if.valid      <= 1'b1;
					upd_if.now_ms     <= nxt.now_ms;
					upd_if.pin_levels <= nxt.pin_levels;
				end else begin
					upd_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare every taken result with the oldest owed one, then pick the next stall.
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (owed_results.size() == 0) begin
					mismatches++;
					$display("%0t: result for channel %0d with nothing expected",
						$time, res_if.sensor_index);
				end else begin
					want = owed_results.pop_front();
					results_checked++;
					if (res_if.beep_event === 1'b1)
						beep_events_seen++;
					check_field("sensor_index", want.sensor_index, res_if.sensor_index);
					check_field("just_pressed", want.just_pressed, res_if.just_pressed);
					check_field("just_released", want.just_released, res_if.just_released);
					check_field("held", want.held, res_if.held);
					check_field("hold_duration_ms", want.hold_duration_ms,
						res_if.hold_duration_ms);
					check_field("beep_count", want.beep_count, res_if.beep_count);
					check_field("beep_event", want.beep_event, res_if.beep_event);
					check_field("last", want.last, res_if.last);
				end
			end
			res_if.ready <= !idle_roll(1'b0);
		end
	end

	// Watchdog: end the run once the total cycle limit is reached.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d results outstanding",
				$time, owed_results.size());
			$display("tb_touch_hold_repeat_tracker failed");
			$finish;
		end
	end

	task automatic add_update(input logic [DUR_W-1:0] now, input logic [PIN_W-1:0] levels);
		update_t u;
		u.now_ms     = now;
		u.pin_levels = levels;
		pending_updates.push_back(u);
		stim_now = now;
		stim_lv  = levels;
	endtask

	// Hold until every queued item is taken and every owed result has arrived.
	task automatic wait_drained();
		while (pending_updates.size() != 0 || upd_if.valid || owed_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the beep interval over APB, then read it back.
	task automatic set_interval(input logic [IVL_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_BEEP_INTERVAL, 2'b00};
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		beep_ivl = v;
		settings_written++;

		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(v)) begin
			mismatches++;
			$display("%0t: beep interval readback mismatch, expected %0h, actual %0h",
				$time, PDATA_W'(v), prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random updates: mostly time creeping forward in interval-sized steps with
	// long holds, plus occasional leaps, backward steps and scrambled levels.
	task automatic queue_random(input int n);
		int unsigned r;
		int unsigned step_max;
		logic [DUR_W-1:0] now;
		logic [PIN_W-1:0] lv;
		for (int k = 0; k < n; k++) begin
			r        = $urandom_range(0, 99);
			step_max = (beep_ivl == '0) ? 5000 : 2 * beep_ivl;
			now      = stim_now;
			lv       = stim_lv;
			if (r < 4)
				now = $urandom;
			else if (r < 8)
				now = now - $urandom_range(1, step_max);
			else if (r < 18)
				now = now + $urandom_range(0, 300 * step_max);
			else
				now = now + $urandom_range(0, step_max);
			if ($urandom_range(0, 9) == 0) begin
				lv = PIN_W'($urandom_range(0, 7));
			end else begin
				for (int b = 0; b < PIN_W; b++)
					if ($urandom_range(0, 99) < 12)
						lv[b] = ~lv[b];
			end
			add_update(now, lv);
		end
	endtask

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		upd_if.valid      = 1'b0;
		upd_if.now_ms     = '0;
		upd_if.pin_levels = '0;
		res_if.ready      = 1'b0;
		pace              = PACE_NONE;
		drain_hold        = 1'b0;
		stim_now          = '0;
		stim_lv           = '0;
		beep_ivl          = BEEP_INTERVAL_RST;
		for (int ch = 0; ch < SENSORS; ch++) begin
			was_touched[ch] = 1'b0;
			press_ms[ch]    = '0;
			beeps_held[ch]  = '0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset interval of 1000 ms.
		add_update(32'd0, 3'b000);           // all idle
		add_update(32'd100, 3'b111);         // press all, duration zero
		add_update(32'd1100, 3'b111);        // exactly one interval: first beep
		add_update(32'd1999, 3'b111);        // just short of the second beep
		add_update(32'd3500, 3'b101);        // jump to three beeps, release channel 1
		add_update(32'd3500, 3'b010);        // swap: channel 1 presses, others release
		add_update(32'hFFFF_FFF0, 3'b010);   // huge hold: count saturates
		add_update(32'hFFFF_FFFF, 3'b010);   // saturated, no further event
		add_update(32'd5, 3'b010);           // time wraps past zero
		add_update(32'd100, 3'b000);         // release from saturation
		add_update(32'hFFFF_FFFF, 3'b111);   // press at the top of the clock
		add_update(32'd999, 3'b111);         // wrapped duration of one interval
		add_update(32'd500, 3'b111);         // time running backwards
		add_update(32'h5555_5555, 3'b011);
		add_update(32'hAAAA_AAAA, 3'b110);
		add_update(32'd0, 3'b000);
		wait_drained();

		// Interval zero: holds of any length never beep.
		set_interval('0);
		add_update(32'd10, 3'b111);
		add_update(32'd100_000, 3'b111);
		add_update(32'hFFFF_FFFF, 3'b111);
		pace = PACE_SRC;
		queue_random(60);
		wait_drained();

		// Shortest interval: counts climb to the limit quickly.
		set_interval(IVL_W'(1));
		pace = PACE_SNK;
		queue_random(90);
		wait_drained();

		// Longest interval.
		set_interval('1);
		pace = PACE_BOTH;
		queue_random(80);
		wait_drained();

		// Random interval, with the sender holding off mid-stream until all results are in.
		set_interval(IVL_W'($urandom_range(2, 3000)));
		pace = PACE_SRC;
		queue_random(50);
		while (pending_updates.size() != 0)
			@(posedge clk);
		drain_hold = 1'b1;
		queue_random(50);
		while (upd_if.valid || owed_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
		drain_hold = 1'b0;
		wait_drained();

		// Small odd interval, no idling.
		set_interval(IVL_W'(7));
		pace = PACE_NONE;
		queue_random(90);
		wait_drained();

		// Back to the reset value under mixed stalls.
		set_interval(BEEP_INTERVAL_RST);
		pace = PACE_BOTH;
		queue_random(80);
		wait_drained();

		// Let any stray result show itself before closing.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Summary: %0d updates taken, %0d channel results checked, %0d beep events",
			updates_taken, results_checked, beep_events_seen);
		$display("Summary: %0d interval settings written, intervals 0, 1, 7, 1000 and 65535",
			settings_written);
		if (mismatches == 0) begin
			$display("tb_touch_hold_repeat_tracker passed");
		end else begin
			$display("tb_touch_hold_repeat_tracker failed");
		end
		$finish;
	end

endmodule
